[sv/mil_pkg.sv]
package mil_pkg;

  // Command codes
  localparam logic [1:0] CMD_F1    = 2'd0;
  localparam logic [1:0] CMD_F2345 = 2'd1;
  localparam logic [1:0] CMD_F5S   = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // Configuration register indexes; the last index has no register behind it.
  localparam logic [1:0] CFG_OP_HI  = 2'd0;
  localparam logic [1:0] CFG_OP_LO  = 2'd1;
  localparam logic [1:0] CFG_OP_PRE = 2'd2;
  localparam logic [1:0] CFG_SPARE  = 2'd3;

  // Rotation amounts in 32-bit words
  localparam logic [1:0] ROT_0  = 2'd0;
  localparam logic [1:0] ROT_4  = 2'd1;
  localparam logic [1:0] ROT_8  = 2'd2;
  localparam logic [1:0] ROT_12 = 2'd3;

  // Constants xored into the last byte of each output block
  localparam logic [127:0] C2 = 128'h1;
  localparam logic [127:0] C3 = 128'h2;
  localparam logic [127:0] C4 = 128'h4;
  localparam logic [127:0] C5 = 128'h8;

  localparam logic [3:0] LAST_ROUND = 4'd10;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_t;

  typedef enum logic [2:0] {
    PH_OPC, PH_TEMP, PH_OUT1, PH_OUT2, PH_OUT3, PH_OUT4, PH_OUT5
  } phase_t;

  // Status of the round core seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } aes_stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // One column of MixColumns, first byte in the top bits
  function automatic logic [31:0] mix_col(input logic [31:0] col);
    logic [7:0] a0, a1, a2, a3, t;
    a0 = col[31:24];
    a1 = col[23:16];
    a2 = col[15:8];
    a3 = col[7:0];
    t  = a0 ^ a1 ^ a2 ^ a3;
    return {a0 ^ t ^ xtime(a0 ^ a1), a1 ^ t ^ xtime(a1 ^ a2),
            a2 ^ t ^ xtime(a2 ^ a3), a3 ^ t ^ xtime(a3 ^ a0)};
  endfunction

  // One cipher round; byte 0 sits in the top bits of the block.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [127:0] u;
    logic [127:0] m;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        u[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[127 - 32 * c -: 32] = mix_col(u[127 - 32 * c -: 32]);
    end
    return (last ? u : m) ^ rk;
  endfunction

  // Next round key of the AES-128 schedule
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, t;
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    return {w0, w1, w2, w2 ^ w3};
  endfunction

  // Rotate a block left by whole 32-bit words
  function automatic logic [127:0] rot_words(input logic [127:0] v, input logic [1:0] sel);
    logic [127:0] r;
    unique case (sel)
      ROT_0:   r = v;
      ROT_4:   r = {v[95:0], v[127:96]};
      ROT_8:   r = {v[63:0], v[127:64]};
      ROT_12:  r = {v[31:0], v[127:32]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

[sv/mil_aes_core.sv]
module mil_aes_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [127:0]             key,
  input  logic [127:0]             blk,
  output logic [127:0]             result,
  output mil_pkg::aes_stat_t       stat
);

  logic [127:0] state;
  logic [127:0] rkey;
  logic [7:0]   rcon;
  logic [3:0]   round;
  logic         busy;
  logic         done;
  logic [127:0] rkey_next;

  // Round key for the round being worked on
  assign rkey_next = mil_pkg::key_next(rkey, rcon);

  // Control: one round per cycle after the initial key add
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      round <= '0;
    end else begin
      done <= busy && (round == mil_pkg::LAST_ROUND);
      if (start) begin
        busy  <= 1'b1;
        round <= 4'd1;
      end else if (busy) begin
        if (round == mil_pkg::LAST_ROUND) begin
          busy <= 1'b0;
        end
        round <= round + 4'd1;
      end
    end
  end

  // Datapath: block state, round key and round constant
  always_ff @(posedge clk) begin
    if (start) begin
      state <= blk ^ key;
      rkey  <= key;
      rcon  <= 8'h01;
    end else if (busy) begin
      state <= mil_pkg::aes_round(state, rkey_next, round == mil_pkg::LAST_ROUND);
      rkey  <= rkey_next;
      rcon  <= mil_pkg::xtime(rcon);
    end
  end

  assign result    = state;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[sv/milenage_auth_functions_unit.sv]
// Each cipher pass runs the round core through all its rounds; an item takes 2 to 5 passes,
// and its result is then loaded into the output register. An unknown command goes from idle
// straight to the output state with no pass. Flow: one item at a time; a new request is taken
// only in idle, the output waits on m_tready, and the single round core runs one round per cycle.
// Reset: rst is synchronous and active high; it clears the sequencer, the output valid
// and the OP registers.
module milenage_auth_functions_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // command, key_high, key_low, rand_high, rand_low, sequence_number, auth_mgmt_field
  input  logic [327:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // done_command, mac_network, mac_resync, response, anonymity_key, cipher_key_high,
  // cipher_key_low, integrity_key_high, integrity_key_low
  output logic [503:0] m_tdata
);

  mil_pkg::state_t   state, state_next;
  mil_pkg::phase_t   phase, phase_next;
  mil_pkg::aes_stat_t core_stat;

  logic [63:0]  op_hi, op_lo;
  logic         op_pre;
  logic [127:0] op;
  logic [1:0]   cmd;
  logic [127:0] key, rnd;
  logic [127:0] in_key, in_rnd;
  logic [47:0]  sqn;
  logic [15:0]  amf;
  logic [127:0] opc, temp;
  logic [127:0] core_res, core_key, core_blk, res_opc, in1;
  logic         core_start;
  logic [63:0]  mac_n, mac_s, resp;
  logic [47:0]  ak;
  logic [127:0] ck, ik;
  logic         s_acc, load_out;

  // K and RAND of the incoming request, high half first
  assign in_key   = {s_tdata[65:2], s_tdata[129:66]};
  assign in_rnd   = {s_tdata[193:130], s_tdata[257:194]};

  assign op       = {op_hi, op_lo};
  assign s_acc    = s_tvalid && s_tready;
  assign s_tready = (state == mil_pkg::ST_IDLE);
  assign res_opc  = core_res ^ opc;
  assign in1      = {sqn, amf, sqn, amf};
  assign core_key = (state == mil_pkg::ST_IDLE) ? in_key : key;
  assign load_out = (state == mil_pkg::ST_OUT) && (!m_tvalid || m_tready);

  mil_aes_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (core_start),
    .key    (core_key),
    .blk    (core_blk),
    .result (core_res),
    .stat   (core_stat)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      op_hi  <= '0;
      op_lo  <= '0;
      op_pre <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mil_pkg::CFG_OP_HI:  op_hi  <= cfg_data;
        mil_pkg::CFG_OP_LO:  op_lo  <= cfg_data;
        mil_pkg::CFG_OP_PRE: op_pre <= cfg_data[0];
        default:             ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mil_pkg::ST_IDLE;
      phase <= mil_pkg::PH_OPC;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // Next step and the block fed to the core
  always_comb begin
    state_next = state;
    phase_next = phase;
    core_start = 1'b0;
    core_blk   = '0;
    unique case (state)
      mil_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tdata[1:0] == mil_pkg::CMD_NONE) begin
            state_next = mil_pkg::ST_OUT;
          end else begin
            state_next = mil_pkg::ST_RUN;
            core_start = 1'b1;
            if (op_pre) begin
              phase_next = mil_pkg::PH_TEMP;
              core_blk   = in_rnd ^ op;
            end else begin
              phase_next = mil_pkg::PH_OPC;
              core_blk   = op;
            end
          end
        end
      end
      mil_pkg::ST_RUN: begin
        if (core_stat.done) begin
          unique case (phase)
            mil_pkg::PH_OPC: begin
              core_start = 1'b1;
              core_blk   = rnd ^ core_res ^ op;
              phase_next = mil_pkg::PH_TEMP;
            end
            mil_pkg::PH_TEMP: begin
              core_start = 1'b1;
              unique case (cmd)
                mil_pkg::CMD_F1: begin
                  core_blk   = core_res ^ mil_pkg::rot_words(in1 ^ opc, mil_pkg::ROT_8);
                  phase_next = mil_pkg::PH_OUT1;
                end
                mil_pkg::CMD_F2345: begin
                  core_blk   = mil_pkg::rot_words(res_opc, mil_pkg::ROT_0) ^ mil_pkg::C2;
                  phase_next = mil_pkg::PH_OUT2;
                end
                default: begin
                  core_blk   = mil_pkg::rot_words(res_opc, mil_pkg::ROT_12) ^ mil_pkg::C5;
                  phase_next = mil_pkg::PH_OUT5;
                end
              endcase
            end
            mil_pkg::PH_OUT2: begin
              core_start = 1'b1;
              core_blk   = mil_pkg::rot_words(temp ^ opc, mil_pkg::ROT_4) ^ mil_pkg::C3;
              phase_next = mil_pkg::PH_OUT3;
            end
            mil_pkg::PH_OUT3: begin
              core_start = 1'b1;
              core_blk   = mil_pkg::rot_words(temp ^ opc, mil_pkg::ROT_8) ^ mil_pkg::C4;
              phase_next = mil_pkg::PH_OUT4;
            end
            default: begin
              state_next = mil_pkg::ST_OUT;
            end
          endcase
        end
      end
      mil_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = mil_pkg::ST_IDLE;
        end
      end
      default: state_next = mil_pkg::ST_IDLE;
    endcase
  end

  // Request fields and the intermediate values OPc and TEMP
  always_ff @(posedge clk) begin
    if (s_acc) begin
      cmd <= s_tdata[1:0];
      key <= in_key;
      rnd <= in_rnd;
      sqn <= s_tdata[305:258];
      amf <= s_tdata[321:306];
      opc <= op;
    end else if (core_stat.done && (phase == mil_pkg::PH_OPC)) begin
      opc <= core_res ^ op;
    end
    if (core_stat.done && (phase == mil_pkg::PH_TEMP)) begin
      temp <= core_res;
    end
  end

  // Result fields, cleared for each new request
  always_ff @(posedge clk) begin
    if (s_acc) begin
      mac_n <= '0;
      mac_s <= '0;
      resp  <= '0;
      ak    <= '0;
      ck    <= '0;
      ik    <= '0;
    end else if (core_stat.done) begin
      unique case (phase)
        mil_pkg::PH_OUT1: begin
          mac_n <= res_opc[127:64];
          mac_s <= res_opc[63:0];
        end
        mil_pkg::PH_OUT2: begin
          resp <= res_opc[63:0];
          ak   <= res_opc[127:80];
        end
        mil_pkg::PH_OUT3: ck <= res_opc;
        mil_pkg::PH_OUT4: ik <= res_opc;
        mil_pkg::PH_OUT5: ak <= res_opc[127:80];
        default:          ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {6'd0, ik[63:0], ik[127:64], ck[63:0], ck[127:64], ak, resp, mac_s, mac_n, cmd};
    end
  end

`ifndef SYNTHESIS
  a_idle_core_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == mil_pkg::ST_IDLE) |-> !core_stat.busy)
    else $error("round core busy while sequencer idle");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    core_stat.done |-> (state == mil_pkg::ST_RUN))
    else $error("core finished outside a run");

  a_unknown_cmd: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (s_tdata[1:0] == mil_pkg::CMD_NONE)) |=> (state == mil_pkg::ST_OUT))
    else $error("unknown command did not go straight to output");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid)
    else $error("result load lost");
`endif

endmodule
